FILE: hw/rtl/fms_pkg.sv
// ----------------------------------------------------------------------------
// fms_pkg
// shared types and defaults for the fowlkes-mallows score block
// ----------------------------------------------------------------------------
`default_nettype none

package fms_pkg;

    localparam int NUM_LABELS_DEF      = 16;
    localparam int COUNT_BITS_DEF      = 16;
    localparam int SCORE_FRAC_BITS_DEF = 16;

    localparam int LABEL_W  = 4;
    localparam int OP_W     = 2;
    localparam int ACC_W    = 32;
    localparam int ROOT_W   = 32;
    localparam int SCORE_W  = 17;
    localparam int SAMPLE_W = 16;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 136;

    // item operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REPORT = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    // command into the count tables
    typedef struct packed {
        logic               add;
        logic               clear;
        logic [LABEL_W-1:0] true_label;
        logic [LABEL_W-1:0] pred_label;
    } t_tbl_cmd;

    // result of the score unit
    typedef struct packed {
        logic              done;
        logic              undef;
        logic [ROOT_W-1:0] root;
    } t_score_res;

endpackage

`default_nettype wire

FILE: hw/rtl/fms_mul.sv
// ----------------------------------------------------------------------------
// fms_mul
// shared 32 x 32 multiplier with registered product
// ----------------------------------------------------------------------------
`default_nettype none

module fms_mul (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [63:0] o_p
);

    logic [63:0] r_p;

    // one product per cycle
    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

FILE: hw/rtl/fms_tbl.sv
// ----------------------------------------------------------------------------
// fms_tbl
// contingency table, row and column totals and the pair counters
// ----------------------------------------------------------------------------
`default_nettype none

module fms_tbl #(
    parameter int NUM_LABELS = fms_pkg::NUM_LABELS_DEF,
    parameter int COUNT_BITS = fms_pkg::COUNT_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire fms_pkg::t_tbl_cmd     i_cmd,
    output logic                       o_busy,
    output logic [fms_pkg::ACC_W-1:0]  o_tk,
    output logic [fms_pkg::ACC_W-1:0]  o_pk,
    output logic [fms_pkg::ACC_W-1:0]  o_qk,
    output logic [COUNT_BITS-1:0]      o_samples,
    output logic                       o_overflow
);

    import fms_pkg::*;

    localparam int CELLS  = NUM_LABELS * NUM_LABELS;
    localparam int LBL_W  = $clog2(NUM_LABELS);
    localparam int CELL_AW = $clog2(CELLS);
    localparam logic [CELL_AW-1:0] CELL_LAST = CELL_AW'(CELLS - 1);

    typedef enum logic [2:0] {
        T_CLR  = 3'b001,
        T_IDLE = 3'b010,
        T_UPD  = 3'b100
    } t_tstate;

    t_tstate r_state;
    logic [CELL_AW-1:0]    r_clr_addr;
    logic [CELL_AW-1:0]    r_cell_addr;
    logic [LBL_W-1:0]      r_row_addr, r_col_addr;
    logic [COUNT_BITS-1:0] r_cell_rd, r_row_rd, r_col_rd;
    logic [COUNT_BITS-1:0] r_samples;
    logic [ACC_W-1:0]      r_tk, r_pk, r_qk;
    logic                  r_overflow;

    logic [COUNT_BITS-1:0] cell_mem [CELLS];
    logic [COUNT_BITS-1:0] row_mem  [NUM_LABELS];
    logic [COUNT_BITS-1:0] col_mem  [NUM_LABELS];

    logic [8:0]            t9, p9;
    logic [16:0]           cell_full;
    logic [CELL_AW-1:0]    in_cell;
    logic [LBL_W-1:0]      in_row, in_col;
    logic                  in_range, full;
    logic                  wr_cell, wr_lbl;
    logic [CELL_AW-1:0]    wa_cell;
    logic [LBL_W-1:0]      wa_row, wa_col;
    logic [COUNT_BITS-1:0] wd_cell, wd_row, wd_col;

    // label decode
    always_comb begin
        t9        = 9'(i_cmd.true_label);
        p9        = 9'(i_cmd.pred_label);
        in_row    = t9[LBL_W-1:0];
        in_col    = p9[LBL_W-1:0];
        cell_full = 17'(t9) * 17'(NUM_LABELS) + 17'(p9);
        in_cell   = cell_full[CELL_AW-1:0];
        in_range  = (32'(t9) < NUM_LABELS) && (32'(p9) < NUM_LABELS);
        full      = &r_samples;
    end

    // memory write select: sweep of zeros or incremented count
    always_comb begin
        wr_cell = 1'b0;
        wr_lbl  = 1'b0;
        wa_cell = r_cell_addr;
        wa_row  = r_row_addr;
        wa_col  = r_col_addr;
        wd_cell = r_cell_rd + COUNT_BITS'(1);
        wd_row  = r_row_rd + COUNT_BITS'(1);
        wd_col  = r_col_rd + COUNT_BITS'(1);
        case (r_state)
            T_CLR: begin
                wr_cell = 1'b1;
                wr_lbl  = 32'(r_clr_addr) < NUM_LABELS;
                wa_cell = r_clr_addr;
                wa_row  = r_clr_addr[LBL_W-1:0];
                wa_col  = r_clr_addr[LBL_W-1:0];
                wd_cell = '0;
                wd_row  = '0;
                wd_col  = '0;
            end
            T_UPD: begin
                wr_cell = 1'b1;
                wr_lbl  = 1'b1;
            end
            default: begin
                wr_cell = 1'b0;
            end
        endcase
    end

    // memories with registered reads
    always_ff @(posedge i_clk) begin
        if (wr_cell) begin
            cell_mem[wa_cell] <= wd_cell;
        end
        if (wr_lbl) begin
            row_mem[wa_row] <= wd_row;
            col_mem[wa_col] <= wd_col;
        end
        r_cell_rd <= cell_mem[in_cell];
        r_row_rd  <= row_mem[in_row];
        r_col_rd  <= col_mem[in_col];
    end

    // saturating accumulate of twice the old count
    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                 input logic [COUNT_BITS-1:0] cnt);
        logic [ACC_W:0] s;
        s = {1'b0, acc} + ((ACC_W+1)'(cnt) << 1);
        return s[ACC_W] ? '1 : s[ACC_W-1:0];
    endfunction

    // sequencer and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= T_CLR;
            r_clr_addr <= '0;
            r_tk       <= '0;
            r_pk       <= '0;
            r_qk       <= '0;
            r_samples  <= '0;
            r_overflow <= 1'b0;
        end else begin
            case (r_state)
                T_CLR: begin
                    r_clr_addr <= r_clr_addr + CELL_AW'(1);
                    if (r_clr_addr == CELL_LAST) begin
                        r_state <= T_IDLE;
                    end
                end
                T_UPD: begin
                    r_tk      <= sat_add(r_tk, r_cell_rd);
                    r_pk      <= sat_add(r_pk, r_row_rd);
                    r_qk      <= sat_add(r_qk, r_col_rd);
                    r_samples <= r_samples + COUNT_BITS'(1);
                    r_state   <= T_IDLE;
                end
                default: begin
                    if (i_cmd.clear) begin
                        r_state    <= T_CLR;
                        r_clr_addr <= '0;
                        r_tk       <= '0;
                        r_pk       <= '0;
                        r_qk       <= '0;
                        r_samples  <= '0;
                        r_overflow <= 1'b0;
                    end else if (i_cmd.add && in_range) begin
                        if (full) begin
                            r_overflow <= 1'b1;
                        end else begin
                            r_state <= T_UPD;
                        end
                    end
                end
            endcase
        end
    end

    // update addresses, latched with the item
    always_ff @(posedge i_clk) begin
        if (r_state == T_IDLE) begin
            r_cell_addr <= in_cell;
            r_row_addr  <= in_row;
            r_col_addr  <= in_col;
        end
    end

    assign o_busy     = (r_state != T_IDLE);
    assign o_tk       = r_tk;
    assign o_pk       = r_pk;
    assign o_qk       = r_qk;
    assign o_samples  = r_samples;
    assign o_overflow = r_overflow;

endmodule

`default_nettype wire

FILE: hw/rtl/fms_score.sv
// ----------------------------------------------------------------------------
// fms_score
// bit-by-bit root search of tk / sqrt(pk * qk) on the shared multiplier
// ----------------------------------------------------------------------------
`default_nettype none

module fms_score #(
    parameter int SCORE_FRAC_BITS = fms_pkg::SCORE_FRAC_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [fms_pkg::ACC_W-1:0] i_tk,
    input  wire logic [fms_pkg::ACC_W-1:0] i_pk,
    input  wire logic [fms_pkg::ACC_W-1:0] i_qk,
    output fms_pkg::t_score_res            o_res
);

    import fms_pkg::*;

    localparam logic [ROOT_W-1:0] ROOT_TOP = ROOT_W'(64'(1) << SCORE_FRAC_BITS);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_PQ   = 11'b00000000010,
        S_TT   = 11'b00000000100,
        S_LD   = 11'b00000001000,
        S_SQ   = 11'b00000010000,
        S_M0   = 11'b00000100000,
        S_M1   = 11'b00001000000,
        S_M2   = 11'b00010000000,
        S_M3   = 11'b00100000000,
        S_M4   = 11'b01000000000,
        S_CMP  = 11'b10000000000
    } t_sstate;

    t_sstate r_state;
    logic [63:0]        r_prod, r_sq;
    logic [127:0]       r_rhs, r_acc;
    logic [ROOT_W-1:0]  r_root, r_bit;
    logic               r_done, r_undef;
    logic [ROOT_W-1:0]  cand;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_p;

    assign cand = r_root | r_bit;

    fms_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_PQ: begin
                mul_a = i_pk;
                mul_b = i_qk;
            end
            S_TT: begin
                mul_a = i_tk;
                mul_b = i_tk;
            end
            S_SQ: begin
                mul_a = cand;
                mul_b = cand;
            end
            S_M0: begin
                mul_a = mul_p[31:0];
                mul_b = r_prod[31:0];
            end
            S_M1: begin
                mul_a = r_sq[31:0];
                mul_b = r_prod[63:32];
            end
            S_M2: begin
                mul_a = r_sq[63:32];
                mul_b = r_prod[31:0];
            end
            S_M3: begin
                mul_a = r_sq[63:32];
                mul_b = r_prod[63:32];
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // sequencer: one result bit per pass of square, multiply and compare
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_PQ;
                    end
                end
                S_PQ: r_state <= S_TT;
                S_TT: begin
                    r_prod  <= mul_p;
                    r_state <= S_LD;
                end
                S_LD: begin
                    r_rhs  <= 128'(mul_p) << (2 * SCORE_FRAC_BITS);
                    r_root <= '0;
                    r_bit  <= ROOT_TOP;
                    if (r_prod == '0) begin
                        r_undef <= 1'b1;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_undef <= 1'b0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: r_state <= S_M0;
                S_M0: begin
                    r_sq    <= mul_p;
                    r_acc   <= '0;
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_acc   <= r_acc + 128'(mul_p);
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_acc   <= r_acc + (128'(mul_p) << 32);
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_acc   <= r_acc + (128'(mul_p) << 32);
                    r_state <= S_M4;
                end
                S_M4: begin
                    r_acc   <= r_acc + (128'(mul_p) << 64);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_acc <= r_rhs) begin
                        r_root <= cand;
                    end
                    r_bit <= r_bit >> 1;
                    if (r_bit[0]) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_SQ;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.done  = r_done;
    assign o_res.undef = r_undef;
    assign o_res.root  = r_undef ? '0 : r_root;

endmodule

`default_nettype wire

FILE: hw/rtl/fowlkes_mallows_score.sv
// add item: accept, then one read-modify-write of cell, row and column
// report item: paced by the shared 32 x 32 multiplier stepping through one root bit
//   per pass; result valid at the edge that ready returns; an undefined score ends
//   before the root search
// clear item, and reset: table sweep over all NUM_LABELS * NUM_LABELS cells, not ready
// reset is synchronous, active low, and starts the sweep; result register is emptied
// ----------------------------------------------------------------------------
// fowlkes_mallows_score
// contingency-table accumulator reporting the fowlkes-mallows index in fixed point
// ----------------------------------------------------------------------------
`default_nettype none

module fowlkes_mallows_score #(
    parameter int NUM_LABELS      = fms_pkg::NUM_LABELS_DEF,
    parameter int COUNT_BITS      = fms_pkg::COUNT_BITS_DEF,
    parameter int SCORE_FRAC_BITS = fms_pkg::SCORE_FRAC_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_s_tvalid,
    output logic                           o_s_tready,
    // op[1:0], true_label[5:2], pred_label[9:6], zero[15:10]
    input  wire logic [fms_pkg::IN_W-1:0]  i_s_tdata,
    output logic                           o_m_tvalid,
    input  wire logic                      i_m_tready,
    // score[16:0], score_undefined[17], overflow[18], sample_count[34:19],
    // pairs_both[66:35], pairs_true[98:67], pairs_pred[130:99], zero[135:131]
    output logic [fms_pkg::OUT_W-1:0]      o_m_tdata
);

    import fms_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCORE = 3'b010,
        ST_HOLD  = 3'b100
    } t_state;

    t_state            r_state;
    logic              r_m_tvalid;
    logic [OUT_W-1:0]  r_m_tdata;

    logic              s_accept;
    t_op               in_op;
    t_tbl_cmd          tbl_cmd;
    logic              tbl_busy, tbl_ovf;
    logic [ACC_W-1:0]  tk, pk, qk;
    logic [COUNT_BITS-1:0] samples;
    logic [31:0]       samples_ext;
    logic              score_start;
    t_score_res        score_res;
    logic              out_free;

    assign in_op      = t_op'(i_s_tdata[1:0]);
    assign o_s_tready = (r_state == ST_IDLE) && !tbl_busy;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_m_tvalid || i_m_tready;
    assign samples_ext = 32'(samples);

    // item decode
    always_comb begin
        tbl_cmd.add        = 1'b0;
        tbl_cmd.clear      = 1'b0;
        tbl_cmd.true_label = i_s_tdata[5:2];
        tbl_cmd.pred_label = i_s_tdata[9:6];
        score_start        = 1'b0;
        if (s_accept) begin
            case (in_op)
                OP_ADD:    tbl_cmd.add   = 1'b1;
                OP_CLEAR:  tbl_cmd.clear = 1'b1;
                OP_REPORT: score_start   = 1'b1;
                default:   score_start   = 1'b0;
            endcase
        end
    end

    fms_tbl #(
        .NUM_LABELS (NUM_LABELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_tbl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (tbl_cmd),
        .o_busy     (tbl_busy),
        .o_tk       (tk),
        .o_pk       (pk),
        .o_qk       (qk),
        .o_samples  (samples),
        .o_overflow (tbl_ovf)
    );

    fms_score #(
        .SCORE_FRAC_BITS (SCORE_FRAC_BITS)
    ) u_score (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (score_start),
        .i_tk    (tk),
        .i_pk    (pk),
        .i_qk    (qk),
        .o_res   (score_res)
    );

    // report sequencing and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            if (r_m_tvalid && i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (score_start) begin
                        r_state <= ST_SCORE;
                    end
                end
                ST_SCORE: begin
                    if (score_res.done) begin
                        r_state <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (out_free) begin
                        r_m_tvalid <= 1'b1;
                        r_state    <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_HOLD && out_free) begin
            r_m_tdata <= {5'b0, qk, pk, tk, samples_ext[SAMPLE_W-1:0], tbl_ovf,
                          score_res.undef, score_res.root[SCORE_W-1:0]};
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    // checks
    a_ready_tbl_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !tbl_busy)
        else $error("ready while tables busy");
    a_report_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        score_start |=> r_state == ST_SCORE)
        else $error("report did not start score unit");
    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[17]) |-> o_m_tdata[16:0] == '0)
        else $error("undefined score not zero");
    a_undef_prod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[17]) |-> (o_m_tdata[98:67] == '0 || o_m_tdata[130:99] == '0))
        else $error("undefined with nonzero product");

endmodule

`default_nettype wire
